// ----- rtl/core/lpfh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfh_pkg
// Shared types, codes and reset values for the three-LED indicator controller.
// ----------------------------------------------------------------------------
package lpfh_pkg;

    // Default widths for the time counter and the flash counters
    localparam int LPFH_TIME_WIDTH  = 32;
    localparam int LPFH_COUNT_WIDTH = 8;

    // Fixed field widths
    localparam int LPFH_ACTION_W = 3;
    localparam int LPFH_PULSE_W  = 16;
    localparam int LPFH_FCOUNT_W = 8;
    localparam int LPFH_CFG_IDX_W = 3;
    localparam int LPFH_CFG_DAT_W = 16;

    typedef enum logic [LPFH_ACTION_W-1:0] {
        ACT_TICK        = 3'd0,
        ACT_PULSE_RED   = 3'd1,
        ACT_PULSE_BLUE  = 3'd2,
        ACT_FLASH_RED   = 3'd3,
        ACT_FLASH_YEL   = 3'd4,
        ACT_SET_BOUND   = 3'd5,
        ACT_SET_PROV    = 3'd6,
        ACT_SET_STEADY  = 3'd7
    } t_action;

    // Register indexes
    localparam logic [LPFH_CFG_IDX_W-1:0] CFG_RED_ON      = 3'd0;
    localparam logic [LPFH_CFG_IDX_W-1:0] CFG_RED_OFF     = 3'd1;
    localparam logic [LPFH_CFG_IDX_W-1:0] CFG_YEL_ON      = 3'd2;
    localparam logic [LPFH_CFG_IDX_W-1:0] CFG_YEL_OFF     = 3'd3;
    localparam logic [LPFH_CFG_IDX_W-1:0] CFG_HB_PERIOD   = 3'd4;
    localparam logic [LPFH_CFG_IDX_W-1:0] CFG_HB_ON       = 3'd5;
    localparam logic [LPFH_CFG_IDX_W-1:0] CFG_START_DELAY = 3'd6;
    localparam logic [LPFH_CFG_IDX_W-1:0] CFG_QUEUE_LIMIT = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_FLASH_MS  = 16'd100;
    localparam logic [15:0] RST_HB_PERIOD = 16'd2000;
    localparam logic [15:0] RST_HB_ON     = 16'd200;
    localparam logic [7:0]  RST_START_DLY = 8'd10;
    localparam logic [7:0]  RST_QUEUE_LIM = 8'd10;

    typedef struct packed {
        logic [15:0] red_on_ms;
        logic [15:0] red_off_ms;
        logic [15:0] yel_on_ms;
        logic [15:0] yel_off_ms;
        logic [15:0] hb_period_ms;
        logic [15:0] hb_on_ms;
        logic [7:0]  start_delay_ms;
        logic [7:0]  queue_limit;
    } t_cfg;

    // Flash machine step event towards the LED pins
    typedef struct packed {
        logic fire;     // machine changed the LED this beat
        logic level;    // new LED level when fire is set
    } t_flash_evt;

endpackage

// ----- rtl/core/led_pulse_flash_heartbeat_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pulse_flash_heartbeat_controller
// Red, yellow and blue LED controller: millisecond ticks and commands drive
// pulses, flash-N-times sequences, a provisioning heartbeat and mode flags.
// ----------------------------------------------------------------------------
//  Channel   | Handshake              | Payload
//  ----------+------------------------+-----------------------------------------
//  command   | i_valid / o_ready      | i_action, i_pulse_ms, i_flash_count, i_level
//  status    | o_valid / i_ready      | o_*_led, o_*_flashes_left, o_*_flag
//  config    | i_cfg_wr_en            | i_cfg_index, i_cfg_wdata
//
//  One beat per clock unless status stalls: a beat waits in the input register,
//  then its status lands in the output register. The input register refills
//  in the cycle it hands over, so a full rate stream runs without bubbles; a
//  stalled status register holds both stages. Synchronous active-low reset
//  clears valid bits and state, not payload data; config takes reset values.
// ----------------------------------------------------------------------------
module led_pulse_flash_heartbeat_controller #(
    parameter int TIME_WIDTH        = lpfh_pkg::LPFH_TIME_WIDTH,
    parameter int FLASH_COUNT_WIDTH = lpfh_pkg::LPFH_COUNT_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [lpfh_pkg::LPFH_ACTION_W-1:0]  i_action,
    input  logic [lpfh_pkg::LPFH_PULSE_W-1:0]   i_pulse_ms,
    input  logic [lpfh_pkg::LPFH_FCOUNT_W-1:0]  i_flash_count,
    input  logic                                i_level,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_red_led,
    output logic                                o_yellow_led,
    output logic                                o_blue_led,
    output logic [7:0]                          o_red_flashes_left,
    output logic [7:0]                          o_yellow_flashes_left,
    output logic                                o_bound_flag,
    output logic                                o_waiting_flag,
    output logic                                o_yellow_steady_flag,
    input  logic                                i_cfg_wr_en,
    input  logic [lpfh_pkg::LPFH_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lpfh_pkg::LPFH_CFG_DAT_W-1:0] i_cfg_wdata
);
    import lpfh_pkg::*;

    // input register
    logic                      r_in_valid;
    t_action                   r_action;
    logic [LPFH_PULSE_W-1:0]   r_pulse_ms;
    logic [LPFH_FCOUNT_W-1:0]  r_count;
    logic                      r_level;

    // state
    logic [TIME_WIDTH-1:0] r_now,      n_now;
    logic                  r_pin_r,    n_pin_r;
    logic                  r_pin_y,    n_pin_y;
    logic                  r_pin_b,    n_pin_b;
    logic                  r_red_act,  n_red_act;
    logic [TIME_WIDTH-1:0] r_red_dl,   n_red_dl;
    logic                  r_blu_act,  n_blu_act;
    logic [TIME_WIDTH-1:0] r_blu_dl,   n_blu_dl;
    logic [TIME_WIDTH-1:0] r_hb_last,  n_hb_last;
    logic                  r_bound,    n_bound;
    logic                  r_wait,     n_wait;
    logic                  r_steady,   n_steady;

    // output register
    logic       r_out_valid;
    logic       r_o_red, r_o_yel, r_o_blu;
    logic [7:0] r_o_rleft, r_o_yleft;
    logic       r_o_bound, r_o_wait, r_o_steady;

    t_cfg                          cfg;
    t_flash_evt                    red_evt, yel_evt;
    logic [FLASH_COUNT_WIDTH-1:0]  red_left_nx, yel_left_nx;
    logic [FLASH_COUNT_WIDTH+7:0]  red_left_ext, yel_left_ext;

    logic                  advance;
    logic                  is_tick;
    logic [TIME_WIDTH-1:0] t_use;
    logic [TIME_WIDTH-1:0] red_diff, blu_diff, hb_diff;
    logic                  red_expire, blu_expire, hb_fire;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign is_tick = (r_action == ACT_TICK);
    assign t_use   = is_tick ? (r_now + TIME_WIDTH'(1)) : r_now;

    assign red_diff   = t_use - r_red_dl;
    assign blu_diff   = t_use - r_blu_dl;
    assign hb_diff    = t_use - r_hb_last - TIME_WIDTH'(cfg.hb_period_ms);
    assign red_expire = r_red_act && !red_diff[TIME_WIDTH-1];
    assign blu_expire = r_blu_act && !blu_diff[TIME_WIDTH-1];
    assign hb_fire    = r_wait && !r_bound && !hb_diff[TIME_WIDTH-1];

    lpfh_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lpfh_flash #(
        .TIME_WIDTH        (TIME_WIDTH),
        .FLASH_COUNT_WIDTH (FLASH_COUNT_WIDTH)
    ) u_flash_red (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_tick     (is_tick),
        .i_req      (r_action == ACT_FLASH_RED),
        .i_time     (t_use),
        .i_count    (r_count),
        .i_on_ms    (cfg.red_on_ms),
        .i_off_ms   (cfg.red_off_ms),
        .i_delay_ms (cfg.start_delay_ms),
        .i_limit    (cfg.queue_limit),
        .o_evt      (red_evt),
        .o_left_nx  (red_left_nx)
    );

    lpfh_flash #(
        .TIME_WIDTH        (TIME_WIDTH),
        .FLASH_COUNT_WIDTH (FLASH_COUNT_WIDTH)
    ) u_flash_yel (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_tick     (is_tick),
        .i_req      (r_action == ACT_FLASH_YEL),
        .i_time     (t_use),
        .i_count    (r_count),
        .i_on_ms    (cfg.yel_on_ms),
        .i_off_ms   (cfg.yel_off_ms),
        .i_delay_ms (cfg.start_delay_ms),
        .i_limit    (cfg.queue_limit),
        .o_evt      (yel_evt),
        .o_left_nx  (yel_left_nx)
    );

    assign red_left_ext = {8'd0, red_left_nx};
    assign yel_left_ext = {8'd0, yel_left_nx};

    always_comb begin
        n_now     = r_now;
        n_pin_r   = r_pin_r;
        n_pin_y   = r_pin_y;
        n_pin_b   = r_pin_b;
        n_red_act = r_red_act;
        n_red_dl  = r_red_dl;
        n_blu_act = r_blu_act;
        n_blu_dl  = r_blu_dl;
        n_hb_last = r_hb_last;
        n_bound   = r_bound;
        n_wait    = r_wait;
        n_steady  = r_steady;
        if (advance) begin
            case (r_action)
                ACT_TICK: begin
                    n_now = t_use;
                    if (red_expire) begin
                        n_pin_r   = 1'b0;
                        n_red_act = 1'b0;
                    end
                    if (blu_expire) begin
                        n_blu_act = 1'b0;
                        if (!r_bound) begin
                            n_pin_b = 1'b0;
                        end
                    end
                    // flash steps override the pulse end on the same pin
                    if (red_evt.fire) begin
                        n_pin_r = red_evt.level;
                    end
                    if (yel_evt.fire) begin
                        n_pin_y = yel_evt.level;
                    end
                    if (hb_fire) begin
                        n_pin_b   = 1'b1;
                        n_blu_act = 1'b1;
                        n_blu_dl  = t_use + TIME_WIDTH'(cfg.hb_on_ms);
                        n_hb_last = t_use;
                    end
                end
                ACT_PULSE_RED: begin
                    n_pin_r   = 1'b1;
                    n_red_act = 1'b1;
                    n_red_dl  = r_now + TIME_WIDTH'(r_pulse_ms);
                end
                ACT_PULSE_BLUE: begin
                    n_pin_b   = 1'b1;
                    n_blu_act = 1'b1;
                    n_blu_dl  = r_now + TIME_WIDTH'(r_pulse_ms);
                end
                ACT_SET_BOUND: begin
                    n_bound = r_level;
                    n_pin_b = r_level;
                    n_wait  = !r_level;
                end
                ACT_SET_PROV: begin
                    n_wait = r_level;
                    if (r_level) begin
                        n_hb_last = r_now;
                    end
                end
                ACT_SET_STEADY: begin
                    n_steady = r_level;
                    n_pin_y  = r_level;
                end
                default: begin
                    // flash requests live in the flash machines
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_action   <= t_action'(i_action);
            r_pulse_ms <= i_pulse_ms;
            r_count    <= i_flash_count;
            r_level    <= i_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now     <= '0;
            r_pin_r   <= 1'b0;
            r_pin_y   <= 1'b0;
            r_pin_b   <= 1'b0;
            r_red_act <= 1'b0;
            r_red_dl  <= '0;
            r_blu_act <= 1'b0;
            r_blu_dl  <= '0;
            r_hb_last <= '0;
            r_bound   <= 1'b0;
            r_wait    <= 1'b0;
            r_steady  <= 1'b0;
        end else begin
            r_now     <= n_now;
            r_pin_r   <= n_pin_r;
            r_pin_y   <= n_pin_y;
            r_pin_b   <= n_pin_b;
            r_red_act <= n_red_act;
            r_red_dl  <= n_red_dl;
            r_blu_act <= n_blu_act;
            r_blu_dl  <= n_blu_dl;
            r_hb_last <= n_hb_last;
            r_bound   <= n_bound;
            r_wait    <= n_wait;
            r_steady  <= n_steady;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_red    <= n_pin_r;
            r_o_yel    <= n_pin_y;
            r_o_blu    <= n_pin_b;
            r_o_rleft  <= red_left_ext[7:0];
            r_o_yleft  <= yel_left_ext[7:0];
            r_o_bound  <= n_bound;
            r_o_wait   <= n_wait;
            r_o_steady <= n_steady;
        end
    end

    assign o_valid               = r_out_valid;
    assign o_red_led             = r_o_red;
    assign o_yellow_led          = r_o_yel;
    assign o_blue_led            = r_o_blu;
    assign o_red_flashes_left    = r_o_rleft;
    assign o_yellow_flashes_left = r_o_yleft;
    assign o_bound_flag          = r_o_bound;
    assign o_waiting_flag        = r_o_wait;
    assign o_yellow_steady_flag  = r_o_steady;

    a_status_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("status beat missing after hand-over");

    a_time_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !is_tick) |=> (r_now == $past(r_now)))
        else $error("time moved on a command beat");

    a_time_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && is_tick) |=> (r_now == $past(r_now) + TIME_WIDTH'(1)))
        else $error("time did not step on a tick");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_action)))
        else $error("held command beat lost");

endmodule

// ----- rtl/core/lpfh_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfh_cfg
// Configuration register bank with write port and reset values.
// ----------------------------------------------------------------------------
module lpfh_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [lpfh_pkg::LPFH_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lpfh_pkg::LPFH_CFG_DAT_W-1:0]  i_cfg_wdata,
    output lpfh_pkg::t_cfg                       o_cfg
);
    import lpfh_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_RED_ON:      n_cfg.red_on_ms      = i_cfg_wdata;
                CFG_RED_OFF:     n_cfg.red_off_ms     = i_cfg_wdata;
                CFG_YEL_ON:      n_cfg.yel_on_ms      = i_cfg_wdata;
                CFG_YEL_OFF:     n_cfg.yel_off_ms     = i_cfg_wdata;
                CFG_HB_PERIOD:   n_cfg.hb_period_ms   = i_cfg_wdata;
                CFG_HB_ON:       n_cfg.hb_on_ms       = i_cfg_wdata;
                CFG_START_DELAY: n_cfg.start_delay_ms = i_cfg_wdata[7:0];
                CFG_QUEUE_LIMIT: n_cfg.queue_limit    = i_cfg_wdata[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_on_ms      <= RST_FLASH_MS;
            r_cfg.red_off_ms     <= RST_FLASH_MS;
            r_cfg.yel_on_ms      <= RST_FLASH_MS;
            r_cfg.yel_off_ms     <= RST_FLASH_MS;
            r_cfg.hb_period_ms   <= RST_HB_PERIOD;
            r_cfg.hb_on_ms       <= RST_HB_ON;
            r_cfg.start_delay_ms <= RST_START_DLY;
            r_cfg.queue_limit    <= RST_QUEUE_LIM;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/lpfh_flash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfh_flash
// Flash-N-times machine: queued count, due time and lit phase for one LED.
// ----------------------------------------------------------------------------
module lpfh_flash #(
    parameter int TIME_WIDTH        = lpfh_pkg::LPFH_TIME_WIDTH,
    parameter int FLASH_COUNT_WIDTH = lpfh_pkg::LPFH_COUNT_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_tick,
    input  logic                                i_req,
    input  logic [TIME_WIDTH-1:0]               i_time,
    input  logic [lpfh_pkg::LPFH_FCOUNT_W-1:0]  i_count,
    input  logic [15:0]                         i_on_ms,
    input  logic [15:0]                         i_off_ms,
    input  logic [7:0]                          i_delay_ms,
    input  logic [7:0]                          i_limit,
    output lpfh_pkg::t_flash_evt                o_evt,
    output logic [FLASH_COUNT_WIDTH-1:0]        o_left_nx
);
    import lpfh_pkg::*;

    localparam int SW = ((FLASH_COUNT_WIDTH > LPFH_FCOUNT_W) ?
                         FLASH_COUNT_WIDTH : LPFH_FCOUNT_W) + 1;
    localparam logic [SW-1:0] CNT_MAX = SW'((1 << FLASH_COUNT_WIDTH) - 1);

    logic [FLASH_COUNT_WIDTH-1:0] r_left, n_left;
    logic [TIME_WIDTH-1:0]        r_due,  n_due;
    logic                         r_lit,  n_lit;

    logic [TIME_WIDTH-1:0] due_diff;
    logic                  step;
    logic [SW-1:0]         sum;
    logic [SW-1:0]         sat;

    // wrap-safe: due reached when (time - due) is non-negative
    assign due_diff = i_time - r_due;
    assign step     = i_tick && (r_left != '0) && !due_diff[TIME_WIDTH-1];

    always_comb begin
        sum = SW'(r_left) + SW'(i_count);
        sat = sum;
        if (sat > SW'(i_limit)) begin
            sat = SW'(i_limit);
        end
        if (sat > CNT_MAX) begin
            sat = CNT_MAX;
        end
    end

    always_comb begin
        n_left = r_left;
        n_due  = r_due;
        n_lit  = r_lit;
        if (i_en) begin
            if (step) begin
                if (!r_lit) begin
                    n_lit = 1'b1;
                    n_due = i_time + TIME_WIDTH'(i_on_ms);
                end else begin
                    n_lit  = 1'b0;
                    n_left = r_left - FLASH_COUNT_WIDTH'(1);
                    if (r_left != FLASH_COUNT_WIDTH'(1)) begin
                        n_due = i_time + TIME_WIDTH'(i_off_ms);
                    end
                end
            end else if (i_req) begin
                if (r_left == '0) begin
                    n_left = (SW'(i_count) > CNT_MAX) ? '1 : FLASH_COUNT_WIDTH'(i_count);
                    n_due  = i_time + TIME_WIDTH'(i_delay_ms);
                    n_lit  = 1'b0;
                end else begin
                    n_left = FLASH_COUNT_WIDTH'(sat);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_due  <= '0;
            r_lit  <= 1'b0;
        end else begin
            r_left <= n_left;
            r_due  <= n_due;
            r_lit  <= n_lit;
        end
    end

    assign o_evt.fire  = step;
    assign o_evt.level = !r_lit;
    assign o_left_nx   = n_left;

endmodule

// ----- sim/led_pulse_flash_heartbeat_controller_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_pulse_flash_heartbeat_controller_tb
// Self-checking bench for the three-LED controller. Ticks and commands go in
// over the command channel and every status beat is checked, field by field,
// against its table row or a cycle-free behavioural model of the pulses,
// flash sequences, heartbeat and mode flags. A short directed table comes first,
// then random phases under different register settings and handshake pressure.
// ----------------------------------------------------------------------------
module led_pulse_flash_heartbeat_controller_tb;
    import lpfh_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        t_action     action;
        logic [15:0] pulse_ms;
        logic [7:0]  flash_count;
        logic        level;
    } led_cmd_t;

    // Literal order: {red, yellow, blue}, red count, yellow count,
    // {bound, waiting, steady}
    typedef struct packed {
        logic       red_led;
        logic       yellow_led;
        logic       blue_led;
        logic [7:0] red_left;
        logic [7:0] yellow_left;
        logic       bound;
        logic       waiting;
        logic       steady;
    } led_status_t;

    typedef struct packed {
        logic [7:0]  left;
        logic [31:0] due;
        logic        lit;
    } flash_seq_t;

    typedef struct {
        led_cmd_t    cmd;
        bit          typed;
        led_status_t want;
    } dir_row_t;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_valid       = 1'b0;
    logic                      o_ready;
    logic [LPFH_ACTION_W-1:0]  i_action      = '0;
    logic [LPFH_PULSE_W-1:0]   i_pulse_ms    = '0;
    logic [LPFH_FCOUNT_W-1:0]  i_flash_count = '0;
    logic                      i_level       = 1'b0;
    logic                      o_valid;
    logic                      i_ready       = 1'b0;
    logic                      o_red_led;
    logic                      o_yellow_led;
    logic                      o_blue_led;
    logic [7:0]                o_red_flashes_left;
    logic [7:0]                o_yellow_flashes_left;
    logic                      o_bound_flag;
    logic                      o_waiting_flag;
    logic                      o_yellow_steady_flag;
    logic                      i_cfg_wr_en   = 1'b0;
    logic [LPFH_CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [LPFH_CFG_DAT_W-1:0] i_cfg_wdata   = '0;

    led_pulse_flash_heartbeat_controller dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_action              (i_action),
        .i_pulse_ms            (i_pulse_ms),
        .i_flash_count         (i_flash_count),
        .i_level               (i_level),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_red_led             (o_red_led),
        .o_yellow_led          (o_yellow_led),
        .o_blue_led            (o_blue_led),
        .o_red_flashes_left    (o_red_flashes_left),
        .o_yellow_flashes_left (o_yellow_flashes_left),
        .o_bound_flag          (o_bound_flag),
        .o_waiting_flag        (o_waiting_flag),
        .o_yellow_steady_flag  (o_yellow_steady_flag),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_wdata           (i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Behavioural copy of the controller state
    t_cfg        cfg_m;
    logic [31:0] now_m;
    logic        red_m, yel_m, blu_m;
    logic        red_pulse_on, blu_pulse_on;
    logic [31:0] red_pulse_end, blu_pulse_end;
    flash_seq_t  red_seq, yel_seq;
    logic [31:0] hb_last_m;
    logic        bound_m, wait_m, steady_m;

    led_status_t expected_status_q[$];
    int          n_errors       = 0;
    int          beats_checked  = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_reqs      = 0;
    int          holds_taken    = 0;
    int          hold_left      = 0;
    int          idle_cycles    = 0;

    // Wrap-safe: reached once (t - d) is non-negative as a signed value
    function automatic logic deadline_hit(input logic [31:0] t, input logic [31:0] d);
        logic [31:0] diff;
        diff = t - d;
        return ~diff[31];
    endfunction

    function automatic void step_flash(inout flash_seq_t f, inout logic led,
                                       input logic [15:0] on_ms, input logic [15:0] off_ms);
        if (f.left == 8'd0 || !deadline_hit(now_m, f.due))
            return;
        if (!f.lit) begin
            led   = 1'b1;
            f.lit = 1'b1;
            f.due = now_m + 32'(on_ms);
        end else begin
            led    = 1'b0;
            f.lit  = 1'b0;
            f.left = f.left - 8'd1;
            if (f.left != 8'd0)
                f.due = now_m + 32'(off_ms);
        end
    endfunction

    // Idle sequence loads the count as given; a running one saturates at the limit
    function automatic void queue_flash(inout flash_seq_t f, input logic [7:0] n);
        logic [8:0] sum;
        if (f.left == 8'd0) begin
            f.left = n;
            f.due  = now_m + 32'(cfg_m.start_delay_ms);
            f.lit  = 1'b0;
        end else begin
            sum = {1'b0, f.left} + {1'b0, n};
            if (sum > {1'b0, cfg_m.queue_limit})
                sum = {1'b0, cfg_m.queue_limit};
            f.left = sum[7:0];
        end
    endfunction

    function automatic led_status_t next_led_status(input led_cmd_t c);
        logic [31:0] hb_gap;
        case (c.action)
            ACT_TICK: begin
                now_m = now_m + 32'd1;
                if (red_pulse_on && deadline_hit(now_m, red_pulse_end)) begin
                    red_m        = 1'b0;
                    red_pulse_on = 1'b0;
                end
                // bound keeps blue lit when its pulse runs out
                if (blu_pulse_on && deadline_hit(now_m, blu_pulse_end)) begin
                    if (!bound_m)
                        blu_m = 1'b0;
                    blu_pulse_on = 1'b0;
                end
                step_flash(red_seq, red_m, cfg_m.red_on_ms, cfg_m.red_off_ms);
                step_flash(yel_seq, yel_m, cfg_m.yel_on_ms, cfg_m.yel_off_ms);
                if (wait_m && !bound_m) begin
                    hb_gap = now_m - hb_last_m - 32'(cfg_m.hb_period_ms);
                    if (!hb_gap[31]) begin
                        blu_m         = 1'b1;
                        blu_pulse_on  = 1'b1;
                        blu_pulse_end = now_m + 32'(cfg_m.hb_on_ms);
                        hb_last_m     = now_m;
                    end
                end
            end
            ACT_PULSE_RED: begin
                red_m         = 1'b1;
                red_pulse_on  = 1'b1;
                red_pulse_end = now_m + 32'(c.pulse_ms);
            end
            ACT_PULSE_BLUE: begin
                blu_m         = 1'b1;
                blu_pulse_on  = 1'b1;
                blu_pulse_end = now_m + 32'(c.pulse_ms);
            end
            ACT_FLASH_RED: queue_flash(red_seq, c.flash_count);
            ACT_FLASH_YEL: queue_flash(yel_seq, c.flash_count);
            ACT_SET_BOUND: begin
                bound_m = c.level;
                wait_m  = ~c.level;
                blu_m   = c.level;
            end
            ACT_SET_PROV: begin
                wait_m = c.level;
                if (c.level)
                    hb_last_m = now_m;
            end
            ACT_SET_STEADY: begin
                steady_m = c.level;
                yel_m    = c.level;
            end
            default: ;
        endcase
        return {red_m, yel_m, blu_m, red_seq.left, yel_seq.left, bound_m, wait_m, steady_m};
    endfunction

    task automatic compare_field(input string name, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (want_v !== got_v) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("status beat %0d: %s expected %0d, got %0d",
                         beats_checked, name, want_v, got_v);
        end
    endtask

    task automatic check_status();
        led_status_t got, want;
        got = {o_red_led, o_yellow_led, o_blue_led, o_red_flashes_left,
               o_yellow_flashes_left, o_bound_flag, o_waiting_flag, o_yellow_steady_flag};
        if (expected_status_q.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("status beat %0d arrived with nothing outstanding", beats_checked);
        end else begin
            want = expected_status_q.pop_front();
            compare_field("red_led", 8'(want.red_led), 8'(got.red_led));
            compare_field("yellow_led", 8'(want.yellow_led), 8'(got.yellow_led));
            compare_field("blue_led", 8'(want.blue_led), 8'(got.blue_led));
            compare_field("red_flashes_left", want.red_left, got.red_left);
            compare_field("yellow_flashes_left", want.yellow_left, got.yellow_left);
            compare_field("bound_flag", 8'(want.bound), 8'(got.bound));
            compare_field("waiting_flag", 8'(want.waiting), 8'(got.waiting));
            compare_field("yellow_steady_flag", 8'(want.steady), 8'(got.steady));
        end
        beats_checked++;
    endtask

    // Status side: random stalls, plus a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            check_status();
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != holds_taken) begin
            holds_taken <= hold_reqs;
            hold_left   <= HOLD_CYCLES;
            i_ready     <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Called just after a rising edge; returns at the edge the beat is taken
    task automatic send_cmd(input led_cmd_t c, input bit typed, input led_status_t want);
        int          gap = 0;
        led_status_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_action      <= c.action;
        i_pulse_ms    <= c.pulse_ms;
        i_flash_count <= c.flash_count;
        i_level       <= c.level;
        do @(posedge i_clk); while (!o_ready);
        pred = next_led_status(c);
        expected_status_q.push_back(typed ? want : pred);
    endtask

    // Mostly ticks so the timers actually run out between commands
    task automatic send_random(input int n);
        led_cmd_t c;
        int       pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      c.action = ACT_TICK;
            else if (pick < 62) c.action = ACT_PULSE_RED;
            else if (pick < 69) c.action = ACT_PULSE_BLUE;
            else if (pick < 77) c.action = ACT_FLASH_RED;
            else if (pick < 85) c.action = ACT_FLASH_YEL;
            else if (pick < 90) c.action = ACT_SET_BOUND;
            else if (pick < 95) c.action = ACT_SET_PROV;
            else                c.action = ACT_SET_STEADY;
            c.pulse_ms    = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(0, 30));
            c.flash_count = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 6));
            c.level       = 1'($urandom);
            send_cmd(c, 1'b0, '0);
        end
    endtask

    task automatic write_reg(input logic [LPFH_CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            CFG_RED_ON:      cfg_m.red_on_ms      = data;
            CFG_RED_OFF:     cfg_m.red_off_ms     = data;
            CFG_YEL_ON:      cfg_m.yel_on_ms      = data;
            CFG_YEL_OFF:     cfg_m.yel_off_ms     = data;
            CFG_HB_PERIOD:   cfg_m.hb_period_ms   = data;
            CFG_HB_ON:       cfg_m.hb_on_ms       = data;
            CFG_START_DELAY: cfg_m.start_delay_ms = data[7:0];
            CFG_QUEUE_LIMIT: cfg_m.queue_limit    = data[7:0];
            default: ;
        endcase
    endtask

    task automatic drain_status();
        i_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Registers change only with the pipeline empty
    task automatic run_phase(input t_cfg c, input int send_pct, input int rcv_pct,
                             input int n_items, input bit squeeze);
        drain_status();
        write_reg(CFG_RED_ON, c.red_on_ms);
        write_reg(CFG_RED_OFF, c.red_off_ms);
        write_reg(CFG_YEL_ON, c.yel_on_ms);
        write_reg(CFG_YEL_OFF, c.yel_off_ms);
        write_reg(CFG_HB_PERIOD, c.hb_period_ms);
        write_reg(CFG_HB_ON, c.hb_on_ms);
        // upper byte of the narrow registers is junk and must be dropped
        write_reg(CFG_START_DELAY, {8'($urandom), c.start_delay_ms});
        write_reg(CFG_QUEUE_LIMIT, {8'($urandom), c.queue_limit});
        i_cfg_wr_en    <= 1'b0;
        send_idle_pct  = send_pct;
        recv_stall_pct = rcv_pct;
        if (squeeze) begin
            hold_reqs <= hold_reqs + 1;
            send_random(24);
        end
        send_random(n_items);
    endtask

    initial begin
        dir_row_t rows[$];
        t_cfg     rc;

        cfg_m = '{RST_FLASH_MS, RST_FLASH_MS, RST_FLASH_MS, RST_FLASH_MS,
                  RST_HB_PERIOD, RST_HB_ON, RST_START_DLY, RST_QUEUE_LIM};
        now_m         = '0;
        red_m         = 1'b0;
        yel_m         = 1'b0;
        blu_m         = 1'b0;
        red_pulse_on  = 1'b0;
        blu_pulse_on  = 1'b0;
        red_pulse_end = '0;
        blu_pulse_end = '0;
        red_seq       = '0;
        yel_seq       = '0;
        hb_last_m     = '0;
        bound_m       = 1'b0;
        wait_m        = 1'b0;
        steady_m      = 1'b0;

        // pulses of zero and full length, bound blue outliving its pulse,
        // flash counts at both ends and a running count cut back to the limit
        rows.push_back('{{ACT_TICK, 16'd0, 8'd0, 1'b0}, 1'b1,
                         {3'b000, 8'd0, 8'd0, 3'b000}});
        rows.push_back('{{ACT_PULSE_RED, 16'd0, 8'd0, 1'b0}, 1'b1,
                         {3'b100, 8'd0, 8'd0, 3'b000}});
        rows.push_back('{{ACT_TICK, 16'd0, 8'd0, 1'b0}, 1'b1,
                         {3'b000, 8'd0, 8'd0, 3'b000}});
        rows.push_back('{{ACT_PULSE_BLUE, 16'hFFFF, 8'd0, 1'b0}, 1'b1,
                         {3'b001, 8'd0, 8'd0, 3'b000}});
        rows.push_back('{{ACT_SET_BOUND, 16'd0, 8'd0, 1'b1}, 1'b1,
                         {3'b001, 8'd0, 8'd0, 3'b100}});
        rows.push_back('{{ACT_PULSE_BLUE, 16'd0, 8'd0, 1'b0}, 1'b0, '0});
        rows.push_back('{{ACT_TICK, 16'd0, 8'd0, 1'b0}, 1'b1,
                         {3'b001, 8'd0, 8'd0, 3'b100}});
        rows.push_back('{{ACT_SET_BOUND, 16'd0, 8'd0, 1'b0}, 1'b1,
                         {3'b000, 8'd0, 8'd0, 3'b010}});
        rows.push_back('{{ACT_SET_PROV, 16'd0, 8'd0, 1'b1}, 1'b1,
                         {3'b000, 8'd0, 8'd0, 3'b010}});
        rows.push_back('{{ACT_TICK, 16'd0, 8'd0, 1'b0}, 1'b0, '0});
        rows.push_back('{{ACT_SET_PROV, 16'd0, 8'd0, 1'b0}, 1'b1,
                         {3'b000, 8'd0, 8'd0, 3'b000}});
        rows.push_back('{{ACT_SET_STEADY, 16'd0, 8'd0, 1'b1}, 1'b1,
                         {3'b010, 8'd0, 8'd0, 3'b001}});
        rows.push_back('{{ACT_FLASH_YEL, 16'd0, 8'd0, 1'b0}, 1'b1,
                         {3'b010, 8'd0, 8'd0, 3'b001}});
        rows.push_back('{{ACT_FLASH_YEL, 16'd0, 8'd255, 1'b0}, 1'b1,
                         {3'b010, 8'd0, 8'd255, 3'b001}});
        rows.push_back('{{ACT_FLASH_YEL, 16'd0, 8'd0, 1'b0}, 1'b1,
                         {3'b010, 8'd0, 8'd10, 3'b001}});
        rows.push_back('{{ACT_FLASH_RED, 16'd0, 8'd3, 1'b0}, 1'b1,
                         {3'b010, 8'd3, 8'd10, 3'b001}});
        rows.push_back('{{ACT_FLASH_RED, 16'd0, 8'd255, 1'b0}, 1'b1,
                         {3'b010, 8'd10, 8'd10, 3'b001}});
        rows.push_back('{{ACT_SET_STEADY, 16'd0, 8'd0, 1'b0}, 1'b1,
                         {3'b000, 8'd10, 8'd10, 3'b000}});
        rows.push_back('{{ACT_PULSE_RED, 16'hFFFF, 8'd0, 1'b0}, 1'b1,
                         {3'b100, 8'd10, 8'd10, 3'b000}});
        rows.push_back('{{ACT_TICK, 16'd0, 8'd0, 1'b0}, 1'b0, '0});

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k])
            send_cmd(rows[k].cmd, rows[k].typed, rows[k].want);
        send_random(130);

        run_phase('{16'd3, 16'd2, 16'd2, 16'd3, 16'd15, 16'd4, 8'd2, 8'd6},
                  86, 0, 200, 1'b0);
        // zero lengths, heartbeat every tick, limit zero cuts running queues
        run_phase('{16'd5, 16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 8'd0, 8'd0},
                  0, 86, 200, 1'b0);
        run_phase('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    8'd255, 8'd255}, 30, 30, 150, 1'b0);
        run_phase('{16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 8'd0, 8'd1},
                  0, 0, 176, 1'b1);
        repeat (2) begin
            rc.red_on_ms      = 16'($urandom_range(1, 8));
            rc.red_off_ms     = 16'($urandom_range(1, 8));
            rc.yel_on_ms      = 16'($urandom_range(1, 8));
            rc.yel_off_ms     = 16'($urandom_range(1, 8));
            rc.hb_period_ms   = 16'($urandom_range(5, 40));
            rc.hb_on_ms       = 16'($urandom_range(1, 10));
            rc.start_delay_ms = 8'($urandom_range(0, 5));
            rc.queue_limit    = 8'($urandom_range(1, 12));
            if (send_idle_pct == 30)
                run_phase(rc, 86, 0, 300, 1'b0);
            else
                run_phase(rc, 30, 30, 350, 1'b0);
        end

        drain_status();
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && expected_status_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/lpfh_pkg.sv
rtl/core/lpfh_cfg.sv
rtl/core/lpfh_flash.sv
rtl/core/led_pulse_flash_heartbeat_controller.sv
sim/led_pulse_flash_heartbeat_controller_tb.sv
